FILE: src/serial_time_command_deframer_unit_macros.svh
// Assertion macros shared by the serial time command deframer RTL.
`ifndef SERIAL_TIME_COMMAND_DEFRAMER_UNIT_MACROS_SVH
`define SERIAL_TIME_COMMAND_DEFRAMER_UNIT_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define STDCD_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define STDCD_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/stdcd_pkg.sv
// Package: constants, result type and digit decode for the time command deframer.
package stdcd_pkg;

    localparam int FRAME_BUFFER_DEPTH = 32;
    localparam int HEAD_DEPTH         = 12;
    localparam int HEAD_IDX_W         = $clog2(HEAD_DEPTH);
    localparam int WPOS_W             = $clog2(FRAME_BUFFER_DEPTH + 1);
    localparam int TAIL_DEPTH         = 3;

    localparam int S_TDATA_W = 8;
    localparam int M_FIELD_W = 43;
    localparam int M_TDATA_W = ((M_FIELD_W + 7) / 8) * 8;

    localparam logic [7:0] CH_A       = 8'h41;
    localparam logic [7:0] CH_X       = 8'h58;
    localparam logic [7:0] CH_S       = 8'h53;
    localparam logic [7:0] CH_T       = 8'h54;
    localparam logic [7:0] DIGIT_ZERO = 8'd48;
    localparam logic [7:0] SUM_BASE   = 8'd255;

    typedef struct packed {
        logic       frame_checked;
        logic [7:0] computed_sum;
        logic [7:0] received_sum;
        logic       checksum_match;
        logic       set_time;
        logic [7:0] hours;
        logic [7:0] minutes;
        logic [7:0] seconds;
    } result_t;

    // Two ASCII digits to a value, no range check, wraps mod 256.
    function automatic logic [7:0] decode_pair(input logic [7:0] tens, input logic [7:0] units);
        logic [7:0] t;
        logic [7:0] u;
        t = tens - DIGIT_ZERO;
        u = units - DIGIT_ZERO;
        return (t << 3) + (t << 1) + u;
    endfunction

endpackage

FILE: src/stdcd_in_stage.sv
// Input register stage: holds one received byte until the frame core takes it.
module stdcd_in_stage (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [stdcd_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                           take,
    output logic                           in_valid,
    output logic [7:0]                     in_byte
);
    import stdcd_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;

    assign s_tready = !valid_reg || take;

    always_comb begin
        valid_next = valid_reg;
        if (take) begin
            valid_next = 1'b0;
        end
        if (s_tvalid && s_tready) begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            byte_reg <= s_tdata[7:0];
        end
    end

    assign in_valid = valid_reg;
    assign in_byte  = byte_reg;

endmodule

FILE: src/stdcd_frame_core.sv
// Frame state and per-byte decode: buffer, running sum, checksum and time decode.
`include "serial_time_command_deframer_unit_macros.svh"

module stdcd_frame_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step,
    input  logic [7:0]        rx_byte,
    output stdcd_pkg::result_t result
);
    import stdcd_pkg::*;

    logic [7:0]        prev_reg,  prev_next;
    logic              recv_reg,  recv_next;
    logic [WPOS_W-1:0] wpos_reg,  wpos_next;
    logic [7:0]        total_reg, total_next;
    logic [7:0]        head_reg  [HEAD_DEPTH];
    logic [7:0]        head_next [HEAD_DEPTH];
    logic [7:0]        tail_reg  [TAIL_DEPTH];
    logic [7:0]        tail_next [TAIL_DEPTH];
    logic [7:0]        before_sum;
    logic [7:0]        comp_sum;
    logic              restart;

    assign restart = (prev_reg == CH_A) && (rx_byte == CH_A);

    always_comb begin
        prev_next  = prev_reg;
        recv_next  = recv_reg;
        wpos_next  = wpos_reg;
        total_next = total_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        before_sum = '0;
        comp_sum   = '0;
        result     = '0;
        if (step) begin
            // "AA" restarts the frame, stores the first A
            if (restart) begin
                recv_next  = 1'b1;
                wpos_next  = '0;
                if (wpos_next < WPOS_W'(HEAD_DEPTH)) begin
                    head_next[wpos_next[HEAD_IDX_W-1:0]] = CH_A;
                end
                tail_next[0] = tail_next[1];
                tail_next[1] = tail_next[2];
                tail_next[2] = CH_A;
                total_next   = CH_A;
                wpos_next    = wpos_next + WPOS_W'(1);
            end
            if (recv_next) begin
                if (wpos_next < WPOS_W'(HEAD_DEPTH)) begin
                    head_next[wpos_next[HEAD_IDX_W-1:0]] = rx_byte;
                end
                tail_next[0] = tail_next[1];
                tail_next[1] = tail_next[2];
                tail_next[2] = rx_byte;
                total_next   = total_next + rx_byte;
                wpos_next    = wpos_next + WPOS_W'(1);
            end
            // buffer full: drop everything, stop receiving
            if (wpos_next >= WPOS_W'(FRAME_BUFFER_DEPTH)) begin
                recv_next  = 1'b0;
                wpos_next  = '0;
                total_next = '0;
                for (int i = 0; i < HEAD_DEPTH; i++) begin
                    head_next[i] = '0;
                end
                for (int i = 0; i < TAIL_DEPTH; i++) begin
                    tail_next[i] = '0;
                end
            end
            // "XX" ends the frame
            if (recv_next && (prev_reg == CH_X) && (rx_byte == CH_X)) begin
                if ((head_next[0] == CH_A) && (head_next[1] == CH_A)
                        && (wpos_next > WPOS_W'(2))) begin
                    before_sum = total_next - tail_next[0] - tail_next[1] - tail_next[2];
                    comp_sum   = SUM_BASE - before_sum;
                    result.frame_checked  = 1'b1;
                    result.computed_sum   = comp_sum;
                    result.received_sum   = tail_next[0];
                    result.checksum_match = (comp_sum == tail_next[0]);
                    if ((comp_sum == tail_next[0]) && (head_next[2] == CH_S)
                            && (head_next[3] == CH_T)) begin
                        result.set_time = 1'b1;
                        result.hours    = decode_pair(head_next[4], head_next[5]);
                        result.minutes  = decode_pair(head_next[7], head_next[8]);
                        result.seconds  = decode_pair(head_next[10], head_next[11]);
                    end
                end
                wpos_next  = '0;
                total_next = '0;
                for (int i = 0; i < HEAD_DEPTH; i++) begin
                    head_next[i] = '0;
                end
                for (int i = 0; i < TAIL_DEPTH; i++) begin
                    tail_next[i] = '0;
                end
            end
            prev_next = rx_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_reg  <= '0;
            recv_reg  <= 1'b0;
            wpos_reg  <= '0;
            total_reg <= '0;
            for (int i = 0; i < HEAD_DEPTH; i++) begin
                head_reg[i] <= '0;
            end
            for (int i = 0; i < TAIL_DEPTH; i++) begin
                tail_reg[i] <= '0;
            end
        end else begin
            prev_reg  <= prev_next;
            recv_reg  <= recv_next;
            wpos_reg  <= wpos_next;
            total_reg <= total_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
        end
    end

    `STDCD_ASSERT_SAME(a_wpos_below_depth, aclk, aresetn, 1'b1, wpos_reg < WPOS_W'(FRAME_BUFFER_DEPTH), "write position reached buffer depth")
    `STDCD_ASSERT_SAME(a_idle_buffer_empty, aclk, aresetn, !recv_reg, (wpos_reg == '0) && (total_reg == '0), "buffer not empty while not receiving")
    `STDCD_ASSERT_NEXT(a_restart_receives, aclk, aresetn, step && restart, recv_reg, "AA did not turn reception on")

endmodule

FILE: src/stdcd_out_stage.sv
// Result register: packs one result and holds it until the sink takes it.
module stdcd_out_stage (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            load,
    input  stdcd_pkg::result_t              result,
    output logic                            out_free,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [stdcd_pkg::M_TDATA_W-1:0] m_tdata
);
    import stdcd_pkg::*;

    logic                 valid_reg;
    logic                 valid_next;
    logic [M_TDATA_W-1:0] data_reg;
    logic [M_TDATA_W-1:0] data_next;

    assign out_free = !valid_reg || m_tready;

    always_comb begin
        valid_next = valid_reg;
        if (m_tready) begin
            valid_next = 1'b0;
        end
        if (load) begin
            valid_next = 1'b1;
        end
        data_next = M_TDATA_W'({result.seconds, result.minutes, result.hours,
                                result.set_time, result.checksum_match,
                                result.received_sum, result.computed_sum,
                                result.frame_checked});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= data_next;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;

endmodule

FILE: src/serial_time_command_deframer_unit.sv
// Top level of the serial time command deframer.
//
// Takes one received serial byte per request on the s_ side and returns exactly one
// result per byte on the m_ side. "AA" starts a frame, "XX" ends it; at a frame end
// whose buffer opens with "AA" and holds more than two bytes, the block reports the
// computed checksum (255 minus the mod-256 sum of the bytes before the checksum byte)
// next to the received checksum byte, and for a matching "ST" frame raises set_time
// with hours, minutes and seconds decoded from the ASCII digits (unchecked, mod 256).
// All other results are zero. A full buffer (FRAME_BUFFER_DEPTH bytes) drops the frame
// and stops reception until the next "AA". Throughput is one byte per clock while
// the m_ side is ready; each byte passes from the input register to the result
// register, with the frame state updated by single-pass logic in between.
// Either side may stall at any time; a waiting result does not block the next byte
// from entering the input register.
`include "serial_time_command_deframer_unit_macros.svh"

module serial_time_command_deframer_unit (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [7:0] rx_byte
    input  logic [stdcd_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [0] frame_checked, [8:1] computed_sum, [16:9] received_sum, [17] checksum_match,
    // [18] set_time, [26:19] hours, [34:27] minutes, [42:35] seconds, [47:43] zero
    output logic [stdcd_pkg::M_TDATA_W-1:0] m_tdata
);
    import stdcd_pkg::*;

    logic    in_valid;
    logic    out_free;
    logic    advance;
    logic [7:0] in_byte;
    result_t result;

    // byte moves from input register into frame state and result register together
    assign advance = in_valid && out_free;

    stdcd_in_stage u_in_stage (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .take     (advance),
        .in_valid (in_valid),
        .in_byte  (in_byte)
    );

    stdcd_frame_core u_frame_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .rx_byte (in_byte),
        .result  (result)
    );

    stdcd_out_stage u_out_stage (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (advance),
        .result   (result),
        .out_free (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    `STDCD_ASSERT_SAME(a_set_time_needs_match, aclk, aresetn, m_tvalid && m_tdata[18], m_tdata[0] && m_tdata[17], "set_time without a matching checked frame")
    `STDCD_ASSERT_SAME(a_unchecked_is_zero, aclk, aresetn, m_tvalid && !m_tdata[0], m_tdata[18:1] == 18'd0, "checksum fields set on an unchecked byte")
    `STDCD_ASSERT_SAME(a_no_command_no_time, aclk, aresetn, m_tvalid && !m_tdata[18], m_tdata[42:19] == 24'd0, "time fields set without set_time")

endmodule
